// ===== rtl/sgsg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register indexes and link types of the staggered grid sample generator.
package sgsg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_AXES  = 8;
	localparam int AXIS_W    = $clog2(MAX_AXES);
	localparam int COORD_W   = FRAC_BITS;
	localparam int CNT_W     = 16;
	localparam int DIM_W     = 4;
	localparam int MARGIN_W  = 15;
	localparam int SIDE_W    = 16;
	localparam int LIMIT_W   = FRAC_BITS + 1;
	localparam int PROD_W    = CNT_W + SIDE_W;
	localparam int POS_W     = PROD_W + 1;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DIMENSION_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN          = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIDE       = 2'd2;

	localparam logic [DIM_W-1:0]    DIMENSION_COUNT_RST = 4'd2;
	localparam logic [MARGIN_W-1:0] MARGIN_RST          = 15'd3277;
	localparam logic [SIDE_W-1:0]   CELL_SIDE_RST       = 16'd6554;

	localparam logic [LIMIT_W-1:0] UNIT_ONE = LIMIT_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic token;
		logic carry;
	} link_t;

	typedef struct packed {
		logic done;
		logic swap;
	} stat_t;

	typedef struct packed {
		logic clear;
		logic bump;
		logic shift;
	} ctl_t;

endpackage

// ===== rtl/sgsg_cell.sv =====
`timescale 1ns / 1ps
// One axis cell: holds the axis index counter and the coordinate of the current point.
module sgsg_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [sgsg_pkg::AXIS_W-1:0]         idx,
	input  logic [sgsg_pkg::AXIS_W-1:0]         last_idx,
	input  sgsg_pkg::link_t                     link_in,
	input  sgsg_pkg::ctl_t                      ctl,
	input  logic [sgsg_pkg::COORD_W-1:0]        base,
	input  logic [sgsg_pkg::SIDE_W-1:0]         side,
	input  logic [sgsg_pkg::LIMIT_W-1:0]        limit,
	input  logic [sgsg_pkg::COORD_W-1:0]        shift_in,
	output sgsg_pkg::link_t                     link_out,
	output sgsg_pkg::stat_t                     stat,
	output logic [sgsg_pkg::COORD_W-1:0]        pos
);

	logic [sgsg_pkg::CNT_W-1:0]   cnt_q;
	logic [sgsg_pkg::COORD_W-1:0] pos_q;
	sgsg_pkg::link_t              link_q;
	logic [sgsg_pkg::CNT_W-1:0]   cnt_inc;
	logic [sgsg_pkg::PROD_W-1:0]  prod;
	logic [sgsg_pkg::POS_W-1:0]   p;
	logic [sgsg_pkg::COORD_W-1:0] p_sat;
	logic                         over;
	logic                         is_last;

	assign is_last = (idx == last_idx);
	assign cnt_inc = cnt_q + sgsg_pkg::CNT_W'(link_in.carry);
	assign prod    = sgsg_pkg::PROD_W'(cnt_inc) * sgsg_pkg::PROD_W'(side);
	assign p       = sgsg_pkg::POS_W'(prod) + sgsg_pkg::POS_W'(base);
	assign over    = (p > sgsg_pkg::POS_W'(limit));
	assign p_sat   = (p[sgsg_pkg::POS_W-1:sgsg_pkg::COORD_W] != '0) ? '1
		: p[sgsg_pkg::COORD_W-1:0];

	assign stat.done = link_in.token && is_last;
	assign stat.swap = link_in.token && is_last && over;
	assign link_out  = link_q;
	assign pos       = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
			cnt_q  <= '0;
		end else begin
			link_q.token <= link_in.token && !is_last;
			link_q.carry <= link_in.token && over && !is_last;
			if (ctl.clear) begin
				cnt_q <= sgsg_pkg::CNT_W'(ctl.bump);
			end else if (ctl.bump) begin
				cnt_q <= cnt_q + sgsg_pkg::CNT_W'(1);
			end else if (link_in.token) begin
				cnt_q <= over ? '0 : cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.token) begin
			pos_q <= over ? base : p_sat;
		end else if (ctl.clear) begin
			pos_q <= base;
		end else if (ctl.shift) begin
			pos_q <= shift_in;
		end
	end

endmodule

// ===== rtl/staggered_grid_sample_generator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the staggered grid sample generator: configuration, control and the axis cell row.
// Usage:
// A transfer on the request channel with request set asks for the next point of the staggered
// grid; a transfer with request clear is taken and does nothing. Each point leaves as one
// transfer per axis on the result channel, axis 0 first, with last set on the final axis.
// A row of axis cells holds the index counters. A token walks the row one cell per cycle,
// each cell multiplying its index by the cell side and passing its carry on. The FIX state then
// applies a lattice switch; the coordinates then shift out of the row one per cycle while the
// receiver takes them.
// A request is taken only in the idle state, so the block takes the next request once the
// final result of a point is in the output register. A stalled receiver holds the output
// register and the row waits.
// Reset clears the counters, selects the main lattice and loads the register defaults
// (two axes, margin 3277, cell side 6554). Configuration writes take effect at once; the user
// must make them only while the block is idle, as the block itself does not enforce this.
module staggered_grid_sample_generator_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sgsg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sgsg_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  request_valid,
	output logic                                  request_ready,
	input  logic                                  request,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic [sgsg_pkg::COORD_W-1:0]          coordinate,
	output logic [sgsg_pkg::AXIS_W-1:0]           axis,
	output logic                                  shifted,
	output logic                                  last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_FIX  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                      state_q;
	logic [sgsg_pkg::DIM_W-1:0]      dimension_count_q;
	logic [sgsg_pkg::MARGIN_W-1:0]   margin_q;
	logic [sgsg_pkg::SIDE_W-1:0]     cell_side_q;
	logic                            sel_q;
	logic                            start_q;
	logic                            switch_q;
	logic [sgsg_pkg::AXIS_W-1:0]     emit_q;
	logic                            result_valid_q;
	logic [sgsg_pkg::COORD_W-1:0]    coordinate_q;
	logic [sgsg_pkg::AXIS_W-1:0]     axis_q;
	logic                            shifted_q;
	logic                            last_q;

	logic [sgsg_pkg::AXIS_W-1:0]     dims_m1;
	logic [sgsg_pkg::LIMIT_W-1:0]    limit;
	logic [sgsg_pkg::COORD_W-1:0]    base_shift;
	logic [sgsg_pkg::COORD_W-1:0]    base;
	logic                            shift_nonempty;
	logic                            new_sel;
	logic                            base_sel;
	logic                            emit_fire;
	logic                            eval_done;
	logic                            eval_swap;
	sgsg_pkg::ctl_t                  ctl;

	sgsg_pkg::link_t                 link [sgsg_pkg::MAX_AXES+1];
	sgsg_pkg::stat_t                 stat [sgsg_pkg::MAX_AXES];
	logic [sgsg_pkg::COORD_W-1:0]    pos  [sgsg_pkg::MAX_AXES+1];

	always_comb begin
		if (dimension_count_q == '0) begin
			dims_m1 = '0;
		end else if (dimension_count_q > sgsg_pkg::DIM_W'(sgsg_pkg::MAX_AXES)) begin
			dims_m1 = sgsg_pkg::AXIS_W'(sgsg_pkg::MAX_AXES - 1);
		end else begin
			dims_m1 = sgsg_pkg::AXIS_W'(dimension_count_q - sgsg_pkg::DIM_W'(1));
		end
	end

	assign limit          = sgsg_pkg::UNIT_ONE - sgsg_pkg::LIMIT_W'(margin_q);
	assign base_shift     = sgsg_pkg::COORD_W'(margin_q)
		+ sgsg_pkg::COORD_W'(cell_side_q[sgsg_pkg::SIDE_W-1:1]);
	assign shift_nonempty = (sgsg_pkg::LIMIT_W'(base_shift) <= limit);
	assign new_sel        = !sel_q && shift_nonempty;
	assign base_sel       = (state_q == ST_FIX && switch_q) ? new_sel : sel_q;
	assign base           = base_sel ? base_shift : sgsg_pkg::COORD_W'(margin_q);
	assign emit_fire      = (state_q == ST_EMIT) && (!result_valid_q || result_ready);

	assign ctl.clear = (state_q == ST_FIX) && switch_q;
	assign ctl.bump  = (state_q == ST_FIX);
	assign ctl.shift = emit_fire;

	always_comb begin
		eval_done = 1'b0;
		eval_swap = 1'b0;
		for (int i = 0; i < sgsg_pkg::MAX_AXES; i++) begin
			eval_done = eval_done | stat[i].done;
			eval_swap = eval_swap | stat[i].swap;
		end
	end

	assign link[0].token            = start_q;
	assign link[0].carry            = 1'b0;
	assign pos[sgsg_pkg::MAX_AXES]  = '0;

	for (genvar g = 0; g < sgsg_pkg::MAX_AXES; g++) begin : g_cell
		sgsg_pkg::ctl_t cell_ctl;

		assign cell_ctl.clear = ctl.clear;
		assign cell_ctl.bump  = ctl.bump && (g == 0);
		assign cell_ctl.shift = ctl.shift;

		sgsg_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (sgsg_pkg::AXIS_W'(g)),
			.last_idx (dims_m1),
			.link_in  (link[g]),
			.ctl      (cell_ctl),
			.base     (base),
			.side     (cell_side_q),
			.limit    (limit),
			.shift_in (pos[g+1]),
			.link_out (link[g+1]),
			.stat     (stat[g]),
			.pos      (pos[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_count_q <= sgsg_pkg::DIMENSION_COUNT_RST;
			margin_q          <= sgsg_pkg::MARGIN_RST;
			cell_side_q       <= sgsg_pkg::CELL_SIDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sgsg_pkg::REG_DIMENSION_COUNT: begin
					dimension_count_q <= cfg_data[sgsg_pkg::DIM_W-1:0];
				end
				sgsg_pkg::REG_MARGIN: begin
					margin_q <= cfg_data[sgsg_pkg::MARGIN_W-1:0];
				end
				sgsg_pkg::REG_CELL_SIDE: begin
					cell_side_q <= cfg_data[sgsg_pkg::SIDE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sel_q          <= 1'b0;
			start_q        <= 1'b0;
			switch_q       <= 1'b0;
			emit_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			start_q        <= (state_q == ST_IDLE) && request_valid && request;
			result_valid_q <= emit_fire || (result_valid_q && !result_ready);
			case (state_q)
				ST_IDLE: begin
					if (request_valid && request) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (eval_done) begin
						switch_q <= eval_swap;
						state_q  <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (switch_q) begin
						sel_q <= new_sel;
					end
					emit_q  <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						if (emit_q == dims_m1) begin
							state_q <= ST_IDLE;
						end else begin
							emit_q <= emit_q + sgsg_pkg::AXIS_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			coordinate_q <= pos[0];
			axis_q       <= emit_q;
			shifted_q    <= sel_q;
			last_q       <= (emit_q == dims_m1);
		end
	end

	assign request_ready = (state_q == ST_IDLE);
	assign result_valid  = result_valid_q;
	assign coordinate    = coordinate_q;
	assign axis          = axis_q;
	assign shifted       = shifted_q;
	assign last          = last_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the staggered grid sample generator with a built-in grid predictor.
module testbench;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [sgsg_pkg::COORD_W-1:0] coordinate;
		logic [sgsg_pkg::AXIS_W-1:0]  axis;
		logic                         shifted;
		logic                         last;
	} grid_coord_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [sgsg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sgsg_pkg::CFG_W-1:0]     cfg_data;
	logic                           request_valid;
	logic                           request_ready;
	logic                           request;
	logic                           result_valid;
	logic                           result_ready;
	logic [sgsg_pkg::COORD_W-1:0]   coordinate;
	logic [sgsg_pkg::AXIS_W-1:0]    axis;
	logic                           shifted;
	logic                           last;

	// Predictor state, mirroring the index counters, the lattice choice and the registers.
	logic [sgsg_pkg::CNT_W-1:0]    idx_cnt [sgsg_pkg::MAX_AXES];
	logic                          on_shifted;
	logic [sgsg_pkg::DIM_W-1:0]    cfg_dims;
	logic [sgsg_pkg::MARGIN_W-1:0] cfg_margin;
	logic [sgsg_pkg::SIDE_W-1:0]   cfg_side;

	grid_coord_t pending_coords [$];
	int          mismatches;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          hold_requests;
	int          hold_served;
	int          hold_left;
	int          cycle_count;

	staggered_grid_sample_generator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.request_valid (request_valid),
		.request_ready (request_ready),
		.request       (request),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.coordinate    (coordinate),
		.axis          (axis),
		.shifted       (shifted),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Works out the coordinates of the next grid point and queues them.
	function automatic void advance_grid();
		longint      limit;
		longint      base;
		longint      p;
		longint      pos [sgsg_pkg::MAX_AXES];
		int          n;
		int          pass;
		int          i;
		bit          done;
		bit          switched;
		grid_coord_t point_coord;
		limit = (longint'(1) << sgsg_pkg::FRAC_BITS) - longint'(cfg_margin);
		n = int'(cfg_dims);
		if (n < 1)
			n = 1;
		if (n > sgsg_pkg::MAX_AXES)
			n = sgsg_pkg::MAX_AXES;
		done = 1'b0;
		for (pass = 0; pass < 3 && !done; pass++) begin
			base = longint'(cfg_margin) + (on_shifted ? longint'(cfg_side >> 1) : longint'(0));
			switched = 1'b0;
			for (i = 0; i < n && !switched; i++) begin
				p = base + longint'(idx_cnt[i]) * longint'(cfg_side);
				if (p > limit) begin
					if (i + 1 == n) begin
						on_shifted = ~on_shifted;
						foreach (idx_cnt[k])
							idx_cnt[k] = '0;
						switched = 1'b1;
					end else begin
						idx_cnt[i] = '0;
						idx_cnt[i + 1] = idx_cnt[i + 1] + sgsg_pkg::CNT_W'(1);
						p = base;
					end
				end
				pos[i] = p;
			end
			if (!switched)
				done = 1'b1;
		end
		if (!done) begin
			on_shifted = 1'b0;
			foreach (idx_cnt[k])
				idx_cnt[k] = '0;
			for (i = 0; i < n; i++)
				pos[i] = longint'(cfg_margin);
		end
		for (i = 0; i < n; i++) begin
			if (pos[i] < 0)
				point_coord.coordinate = '0;
			else if (pos[i] > longint'(16'hFFFF))
				point_coord.coordinate = '1;
			else
				point_coord.coordinate = sgsg_pkg::COORD_W'(pos[i]);
			point_coord.axis = sgsg_pkg::AXIS_W'(i);
			point_coord.shifted = on_shifted;
			point_coord.last = (i + 1 == n);
			pending_coords.insert(pending_coords.size(), point_coord);
		end
		idx_cnt[0] = idx_cnt[0] + sgsg_pkg::CNT_W'(1);
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t ns: %s", $time, what);
	endtask

	// Each result transfer is compared with the oldest queued coordinate.
	always @(posedge clk) begin : check_results
		grid_coord_t want;
		grid_coord_t got;
		if (arst_n && result_valid && result_ready) begin
			got = '{coordinate: coordinate, axis: axis, shifted: shifted, last: last};
			if (pending_coords.size() == 0) begin
				report_mismatch($sformatf(
					"unexpected result coordinate=%h axis=%0d shifted=%b last=%b",
					got.coordinate, got.axis, got.shifted, got.last));
			end else begin
				want = pending_coords.pop_front();
				if (got.coordinate !== want.coordinate || got.axis !== want.axis ||
						got.shifted !== want.shifted || got.last !== want.last)
					report_mismatch($sformatf({"result mismatch: expected coordinate=%h axis=%0d ",
						"shifted=%b last=%b, got coordinate=%h axis=%0d shifted=%b last=%b"},
						want.coordinate, want.axis, want.shifted, want.last,
						got.coordinate, got.axis, got.shifted, got.last));
			end
		end
	end

	// The receiver stalls at random, and for a long stretch whenever a hold is asked for.
	initial begin
		result_ready = 1'b0;
		hold_served = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** staggered_grid_sample_generator_unit: FAILED **");
		$finish;
	end

	// Offers one request after a random gap; valid stays high after the transfer.
	task automatic send_request(input logic req);
		int gap;
		gap = 0;
		while (gap < 24 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			request_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_valid <= 1'b1;
		request <= req;
		@(posedge clk);
		while (!request_ready)
			@(posedge clk);
		if (req)
			advance_grid();
	endtask

	task automatic settle();
		request_valid <= 1'b0;
		while (pending_coords.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [sgsg_pkg::CFG_IDX_W-1:0] reg_index,
			input logic [sgsg_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (reg_index)
			sgsg_pkg::REG_DIMENSION_COUNT: cfg_dims = data[sgsg_pkg::DIM_W-1:0];
			sgsg_pkg::REG_MARGIN:          cfg_margin = data[sgsg_pkg::MARGIN_W-1:0];
			sgsg_pkg::REG_CELL_SIDE:       cfg_side = data[sgsg_pkg::SIDE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [sgsg_pkg::CFG_W-1:0] dims,
			input logic [sgsg_pkg::CFG_W-1:0] marg, input logic [sgsg_pkg::CFG_W-1:0] side);
		settle();
		write_register(sgsg_pkg::REG_DIMENSION_COUNT, dims);
		write_register(sgsg_pkg::REG_MARGIN, marg);
		write_register(sgsg_pkg::REG_CELL_SIDE, side);
	endtask

	task automatic test_reset_defaults();
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b1);
	endtask

	task automatic test_dimension_extremes();
		logic [sgsg_pkg::CFG_W-1:0] dims_list [4];
		dims_list = '{16'd1, 16'd8, 16'd0, 16'd15};
		foreach (dims_list[k]) begin
			settle();
			write_register(sgsg_pkg::REG_DIMENSION_COUNT, dims_list[k]);
			send_request(1'b1);
			send_request(1'b1);
		end
	endtask

	// Margin zero with half-unit spacing reaches a position of exactly one.
	task automatic test_unit_saturation();
		apply_settings(16'd1, 16'd0, 16'd32768);
		repeat (4) send_request(1'b1);
	endtask

	// The shifted corner lies beyond the limit, so the shifted lattice is skipped.
	task automatic test_empty_shifted();
		apply_settings(16'd2, 16'd30000, 16'd20001);
		repeat (4) send_request(1'b1);
	endtask

	task automatic test_narrow_cube();
		apply_settings(16'hFFF1, 16'hFFFF, 16'd1);
		repeat (3) send_request(1'b1);
	endtask

	task automatic test_zero_side();
		apply_settings(16'd3, 16'd1234, 16'd0);
		repeat (2) send_request(1'b1);
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		apply_settings(16'd8, 16'd1000, 16'd40000);
		hold_requests++;
		repeat (16) send_request(1'b1);
		request_valid <= 1'b0;
		while (pending_coords.size() != 0)
			@(posedge clk);
		repeat (6) send_request(1'b1);
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int points);
		int                            sent;
		int                            phase_len;
		int                            n;
		int                            k;
		int                            span;
		int                            side;
		logic [sgsg_pkg::DIM_W-1:0]    dims;
		logic [sgsg_pkg::MARGIN_W-1:0] marg;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < points) begin
			case ($urandom_range(7))
				0: apply_settings(16'd8, 16'd0, 16'd65535);
				1: apply_settings(16'd1, 16'h7FFF, 16'd1);
				default: begin
					dims = ($urandom_range(9) == 0) ? sgsg_pkg::DIM_W'($urandom_range(15)) :
						sgsg_pkg::DIM_W'($urandom_range(8, 1));
					n = (dims == 0) ? 1 :
						(dims > sgsg_pkg::MAX_AXES ? sgsg_pkg::MAX_AXES : int'(dims));
					marg = sgsg_pkg::MARGIN_W'($urandom);
					span = 65536 - 2 * int'(marg);
					k = $urandom_range(n <= 3 ? 5 : 2, 1);
					side = span / k - 2 + $urandom_range(4);
					if ($urandom_range(5) == 0)
						side = $urandom_range(65535, 1);
					if (side < 1)
						side = 1;
					if (side > 65535)
						side = 65535;
					apply_settings({12'($urandom), dims}, {1'($urandom), marg},
						sgsg_pkg::CFG_W'(side));
				end
			endcase
			phase_len = $urandom_range(50, 20);
			while (phase_len > 0 && sent < points) begin
				if ($urandom_range(9) == 0) begin
					send_request(1'b0);
				end else begin
					send_request(1'b1);
					sent++;
					phase_len--;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		request_valid = 1'b0;
		request = 1'b0;
		mismatches = 0;
		hold_requests = 0;
		tx_idle_pct = 14;
		rx_idle_pct = 58;
		foreach (idx_cnt[k])
			idx_cnt[k] = '0;
		on_shifted = 1'b0;
		cfg_dims = sgsg_pkg::DIMENSION_COUNT_RST;
		cfg_margin = sgsg_pkg::MARGIN_RST;
		cfg_side = sgsg_pkg::CELL_SIDE_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_dimension_extremes();
		test_unit_saturation();
		test_empty_shifted();
		test_narrow_cube();
		test_zero_side();
		test_random_traffic(14, 58, 150);
		test_random_traffic(58, 14, 150);
		test_random_traffic(0, 0, 130);
		test_backpressure();

		settle();
		if (mismatches == 0)
			$display("** staggered_grid_sample_generator_unit: PASSED **");
		else
			$display("** staggered_grid_sample_generator_unit: FAILED **");
		$finish;
	end

endmodule
